[hdl/sse_pkg.sv]
package sse_pkg;

  // Width of one list element.
  localparam int DATA_W = 32;

  // Default depth of the element store.
  localparam int MAX_ELEMENTS_DEF = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_POS,
    ST_FIRST,
    ST_SCAN,
    ST_SWAP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read_pos;
    logic take_pos;
    logic compare;
    logic read_probe;
    logic swap;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic probe_end;
    logic pos_last;
  } status_t;

endpackage

[hdl/sse_ctrl.sv]
module sse_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_item,
  input  sse_pkg::status_t  status,
  output logic              busy,
  output sse_pkg::cmd_t     cmd
);

  sse_pkg::state_t state;
  sse_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sse_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sse_pkg::ST_IDLE: begin
        if (start && last_item) begin
          state_next = sse_pkg::ST_READ_POS;
        end
      end
      sse_pkg::ST_READ_POS: begin
        state_next = sse_pkg::ST_FIRST;
      end
      sse_pkg::ST_FIRST, sse_pkg::ST_SCAN: begin
        if (status.probe_end) begin
          state_next = sse_pkg::ST_SWAP;
        end else begin
          state_next = sse_pkg::ST_SCAN;
        end
      end
      sse_pkg::ST_SWAP: begin
        if (status.pos_last) begin
          state_next = sse_pkg::ST_IDLE;
        end else begin
          state_next = sse_pkg::ST_READ_POS;
        end
      end
      default: begin
        state_next = sse_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      sse_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      sse_pkg::ST_READ_POS: begin
        cmd.read_pos = 1'b1;
      end
      sse_pkg::ST_FIRST: begin
        cmd.take_pos   = 1'b1;
        cmd.read_probe = !status.probe_end;
      end
      sse_pkg::ST_SCAN: begin
        cmd.compare    = 1'b1;
        cmd.read_probe = !status.probe_end;
      end
      sse_pkg::ST_SWAP: begin
        cmd.swap = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[hdl/sse_dp.sv]
module sse_dp #(
  parameter int MAX_ELEMENTS = sse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic signed [sse_pkg::DATA_W-1:0]  value,
  input  sse_pkg::cmd_t                      cmd,
  output sse_pkg::status_t                   status,
  output logic                               result_valid,
  output logic signed [sse_pkg::DATA_W-1:0]  sorted_value,
  output logic                               last_result,
  output logic                               overflowed
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  logic signed [sse_pkg::DATA_W-1:0] mem [MAX_ELEMENTS];

  logic [CW-1:0]                     count;
  logic                              overflow_flag;
  logic [CW-1:0]                     pos;
  logic [CW-1:0]                     probe;
  logic [AW-1:0]                     rd_idx;
  logic signed [sse_pkg::DATA_W-1:0] rdata;
  logic signed [sse_pkg::DATA_W-1:0] posval;
  logic signed [sse_pkg::DATA_W-1:0] minval;
  logic [AW-1:0]                     least;
  logic                              room;

  assign room             = (count < CW'(MAX_ELEMENTS));
  assign status.probe_end = (probe == count);
  assign status.pos_last  = (CW'(pos + CW'(1)) == count);

  // Store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.load && room) begin
      mem[count[AW-1:0]] <= value;
    end else if (cmd.swap) begin
      mem[least] <= posval;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read_pos) begin
      rdata  <= mem[pos[AW-1:0]];
      rd_idx <= pos[AW-1:0];
    end else if (cmd.read_probe) begin
      rdata  <= mem[probe[AW-1:0]];
      rd_idx <= probe[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count         <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd.load) begin
      if (room) begin
        count <= CW'(count + CW'(1));
      end else begin
        overflow_flag <= 1'b1;
      end
    end else if (cmd.swap && status.pos_last) begin
      count         <= '0;
      overflow_flag <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos <= '0;
    end else if (cmd.swap) begin
      pos <= CW'(pos + CW'(1));
    end
    if (cmd.read_pos) begin
      probe <= CW'(pos + CW'(1));
    end else if (cmd.read_probe) begin
      probe <= CW'(probe + CW'(1));
    end
  end

  // Running minimum; a tie keeps the earlier entry.
  always_ff @(posedge clk) begin
    if (cmd.take_pos) begin
      posval <= rdata;
      minval <= rdata;
      least  <= rd_idx;
    end else if (cmd.compare && (minval > rdata)) begin
      minval <= rdata;
      least  <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.swap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.swap) begin
      sorted_value <= minval;
      last_result  <= status.pos_last;
      overflowed   <= overflow_flag;
    end
  end

endmodule

[hdl/selection_sort_engine_unit.sv]
// Selection sort engine. A list of signed 32-bit values is loaded one transaction per
// cycle (start high while busy is low); the transaction with last_item set closes the
// list and busy rises. Values beyond the store depth are dropped and every result of
// that run carries overflowed. The engine then finds, for each position in turn, the
// first strict minimum of the remaining entries by reading the store once per entry,
// and presents that minimum as one result for a single cycle with result_valid high;
// the receiver cannot stall, so it must take every result as it appears. The final
// result carries last_result and busy falls on that same cycle. The element store has a
// single read port, so the scan for each position reads the remaining entries one at a
// time, and a new list is taken only once busy has fallen.
module selection_sort_engine_unit #(
  parameter int MAX_ELEMENTS = sse_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [sse_pkg::DATA_W-1:0]  value,
  input  logic                               last_item,
  output logic                               result_valid,
  output logic signed [sse_pkg::DATA_W-1:0]  sorted_value,
  output logic                               last_result,
  output logic                               overflowed
);

  // The controller sequences load, position fetch, scan and swap; the datapath
  // holds the store, the counters and the running minimum.
  sse_pkg::cmd_t    cmd;
  sse_pkg::status_t status;

  sse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .last_item (last_item),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  sse_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .value        (value),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .sorted_value (sorted_value),
    .last_result  (last_result),
    .overflowed   (overflowed)
  );

`ifndef SYNTHESIS
  // Every result comes from a swap step in the previous cycle.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(cmd.swap))
    else $error("result without a preceding swap");

  // The final result of a run leaves the engine ready for a new list.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_result) |-> !busy)
    else $error("engine still busy after the final result");

  // Datapath steps that write the store or update the minimum never overlap.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.take_pos, cmd.compare, cmd.swap}))
    else $error("overlapping datapath commands");
`endif

endmodule
